FILE: rtl/segint_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_pkg
// Shared types and constants for the segment intersection unit.
// ----------------------------------------------------------------------------
package segint_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int THR_BITS       = 32;
	localparam logic [THR_BITS-1:0] THR_RESET = 32'd1;

	typedef enum logic [1:0] {
		ST_INTERSECT = 2'd0,
		ST_PARALLEL  = 2'd1,
		ST_OUTSIDE   = 2'd2
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/segment_intersection_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Intersection of two line segments in signed fixed point.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes both segments' endpoints; output
// channel (out_valid/out_ready) returns hit, status and the crossing point,
// one result per input transfer, in order. cfg_valid/cfg_ready/cfg_data writes
// the parallel threshold; cfg_ready is always high.
// The pipeline has six stages of differences, products, cross terms,
// classification, partial products and numerator sum, then COORD_BITS + 1
// divider stages, one quotient bit each, then the output register.
// Throughput is one pair per cycle while the output is not stalled.
// Reset clears all valid bits and loads the threshold with 1.
// While out_valid is high and out_ready low, the whole pipeline holds; input
// is taken only while the output register is empty or draining.
// ----------------------------------------------------------------------------
module segment_intersection_unit #(
	parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_BITS-1:0]  a_start_x,
	input  wire logic signed [COORD_BITS-1:0]  a_start_y,
	input  wire logic signed [COORD_BITS-1:0]  a_end_x,
	input  wire logic signed [COORD_BITS-1:0]  a_end_y,
	input  wire logic signed [COORD_BITS-1:0]  b_start_x,
	input  wire logic signed [COORD_BITS-1:0]  b_start_y,
	input  wire logic signed [COORD_BITS-1:0]  b_end_x,
	input  wire logic signed [COORD_BITS-1:0]  b_end_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               hit,
	output segint_pkg::status_t                status,
	output logic signed [COORD_BITS-1:0]       cross_x,
	output logic signed [COORD_BITS-1:0]       cross_y,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [segint_pkg::THR_BITS-1:0] cfg_data
);
	import segint_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int PW  = 2 * DW;
	localparam int DNW = PW + 1;
	localparam int LO  = (DNW + 1) / 2;
	localparam int HI  = DNW - LO;
	localparam int NW  = DNW + DW;
	localparam int QW  = DW;
	localparam int CW  = (DNW > THR_BITS) ? DNW : THR_BITS;
	localparam int SW  = C + 2;

	logic en;
	logic [THR_BITS-1:0] thr_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// stage 1: differences
	logic                 v_s1;
	logic signed [DW-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1, dx13_s1, dy13_s1;
	logic signed [C-1:0]  bx_s1, by_s1;

	// stage 2: products
	logic                 v_s2;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [DW-1:0] dx12_s2, dy12_s2;
	logic signed [C-1:0]  bx_s2, by_s2;

	// stage 3: cross terms
	logic                  v_s3;
	logic signed [DNW-1:0] d_s3, tn_s3, un_s3;
	logic signed [DW-1:0]  dx12_s3, dy12_s3;
	logic signed [C-1:0]   bx_s3, by_s3;

	// stage 4: classification and magnitudes
	logic                 v_s4, hit_s4, negx_s4, negy_s4;
	status_t              st_s4;
	logic [DNW-1:0]       tnm_s4, dm_s4;
	logic [DW-1:0]        mx_s4, my_s4;
	logic signed [C-1:0]  bx_s4, by_s4;

	// stage 5: partial products
	logic                 v_s5, hit_s5, negx_s5, negy_s5;
	status_t              st_s5;
	logic [LO+DW-1:0]     pxl_s5, pyl_s5;
	logic [HI+DW-1:0]     pxh_s5, pyh_s5;
	logic [DNW-1:0]       dm_s5;
	logic signed [C-1:0]  bx_s5, by_s5;

	// stage 6: numerators
	logic                 v_s6, hit_s6, negx_s6, negy_s6;
	status_t              st_s6;
	logic [NW-1:0]        nx_s6, ny_s6;
	logic [DNW-1:0]       dm_s6;
	logic signed [C-1:0]  bx_s6, by_s6;

	logic d_neg, d_par, tn_ok, un_ok;
	logic [DNW-1:0] d_mag;

	assign d_neg = d_s3 < 0;
	assign d_mag = d_neg ? $unsigned(-d_s3) : $unsigned(d_s3);
	assign d_par = (d_s3 == '0) || (CW'(d_mag) < CW'(thr_q));
	assign tn_ok = d_neg ? (tn_s3 <= 0 && tn_s3 >= d_s3) : (tn_s3 >= 0 && tn_s3 <= d_s3);
	assign un_ok = d_neg ? (un_s3 <= 0 && un_s3 >= d_s3) : (un_s3 >= 0 && un_s3 <= d_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx12_s1 <= DW'(a_start_x) - DW'(a_end_x);
			dy12_s1 <= DW'(a_start_y) - DW'(a_end_y);
			dx34_s1 <= DW'(b_start_x) - DW'(b_end_x);
			dy34_s1 <= DW'(b_start_y) - DW'(b_end_y);
			dx13_s1 <= DW'(a_start_x) - DW'(b_start_x);
			dy13_s1 <= DW'(a_start_y) - DW'(b_start_y);
			bx_s1   <= a_start_x;
			by_s1   <= a_start_y;

			pa_s2   <= dx12_s1 * dy34_s1;
			pb_s2   <= dy12_s1 * dx34_s1;
			pc_s2   <= dx13_s1 * dy34_s1;
			pd_s2   <= dy13_s1 * dx34_s1;
			pe_s2   <= dy12_s1 * dx13_s1;
			pf_s2   <= dx12_s1 * dy13_s1;
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;

			d_s3    <= DNW'(pa_s2) - DNW'(pb_s2);
			tn_s3   <= DNW'(pc_s2) - DNW'(pd_s2);
			un_s3   <= DNW'(pe_s2) - DNW'(pf_s2);
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;

			hit_s4  <= !d_par && tn_ok && un_ok;
			st_s4   <= d_par ? ST_PARALLEL : ((tn_ok && un_ok) ? ST_INTERSECT : ST_OUTSIDE);
			tnm_s4  <= (tn_s3 < 0) ? $unsigned(-tn_s3) : $unsigned(tn_s3);
			dm_s4   <= d_mag;
			mx_s4   <= (dx12_s3 < 0) ? $unsigned(-dx12_s3) : $unsigned(dx12_s3);
			my_s4   <= (dy12_s3 < 0) ? $unsigned(-dy12_s3) : $unsigned(dy12_s3);
			negx_s4 <= dx12_s3 > 0;
			negy_s4 <= dy12_s3 > 0;
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;

			pxl_s5  <= (LO+DW)'(tnm_s4[LO-1:0]) * (LO+DW)'(mx_s4);
			pyl_s5  <= (LO+DW)'(tnm_s4[LO-1:0]) * (LO+DW)'(my_s4);
			pxh_s5  <= (HI+DW)'(tnm_s4[DNW-1:LO]) * (HI+DW)'(mx_s4);
			pyh_s5  <= (HI+DW)'(tnm_s4[DNW-1:LO]) * (HI+DW)'(my_s4);
			dm_s5   <= dm_s4;
			hit_s5  <= hit_s4;
			st_s5   <= st_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			bx_s5   <= bx_s4;
			by_s5   <= by_s4;

			nx_s6   <= NW'(pxl_s5) + (NW'(pxh_s5) << LO);
			ny_s6   <= NW'(pyl_s5) + (NW'(pyh_s5) << LO);
			dm_s6   <= dm_s5;
			hit_s6  <= hit_s5;
			st_s6   <= st_s5;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			bx_s6   <= bx_s5;
			by_s6   <= by_s5;
		end
	end

	logic [QW-1:0] qx, qy;

	segint_div #(.DEN_W(DNW), .QUO_W(QW)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_s6),
		.den (dm_s6),
		.quo (qx)
	);

	segint_div #(.DEN_W(DNW), .QUO_W(QW)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_s6),
		.den (dm_s6),
		.quo (qy)
	);

	// sideband alongside the divider
	logic                v_dl    [QW];
	logic                hit_dl  [QW];
	status_t             st_dl   [QW];
	logic                negx_dl [QW];
	logic                negy_dl [QW];
	logic signed [C-1:0] bx_dl   [QW];
	logic signed [C-1:0] by_dl   [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				v_dl[k] <= 1'b0;
			end
		end else if (en) begin
			v_dl[0] <= v_s6;
			for (int k = 1; k < QW; k++) begin
				v_dl[k] <= v_dl[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_dl[0]  <= hit_s6;
			st_dl[0]   <= st_s6;
			negx_dl[0] <= negx_s6;
			negy_dl[0] <= negy_s6;
			bx_dl[0]   <= bx_s6;
			by_dl[0]   <= by_s6;
			for (int k = 1; k < QW; k++) begin
				hit_dl[k]  <= hit_dl[k-1];
				st_dl[k]   <= st_dl[k-1];
				negx_dl[k] <= negx_dl[k-1];
				negy_dl[k] <= negy_dl[k-1];
				bx_dl[k]   <= bx_dl[k-1];
				by_dl[k]   <= by_dl[k-1];
			end
		end
	end

	// output register
	logic signed [SW-1:0] sum_x, sum_y;

	assign sum_x = negx_dl[QW-1] ? SW'(bx_dl[QW-1]) - SW'({1'b0, qx})
	                             : SW'(bx_dl[QW-1]) + SW'({1'b0, qx});
	assign sum_y = negy_dl[QW-1] ? SW'(by_dl[QW-1]) - SW'({1'b0, qy})
	                             : SW'(by_dl[QW-1]) + SW'({1'b0, qy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_dl[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= hit_dl[QW-1];
			status  <= st_dl[QW-1];
			cross_x <= hit_dl[QW-1] ? sum_x[C-1:0] : '0;
			cross_y <= hit_dl[QW-1] ? sum_y[C-1:0] : '0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/segint_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits (numerator below den << QUO_W).
// ----------------------------------------------------------------------------
module segint_div #(
	parameter int DEN_W = 51,
	parameter int QUO_W = 25
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [DEN_W+QUO_W-1:0]   num,
	input  wire logic [DEN_W-1:0]         den,
	output logic      [QUO_W-1:0]         quo
);
	localparam int NUM_W = DEN_W + QUO_W;

	logic [DEN_W-1:0] rem_in [QUO_W];
	logic [QUO_W-1:0] low_in [QUO_W];
	logic [QUO_W-1:0] quo_in [QUO_W];
	logic [DEN_W-1:0] den_in [QUO_W];

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];

	always_comb begin
		rem_in[0] = num[NUM_W-1:QUO_W];
		low_in[0] = num[QUO_W-1:0];
		quo_in[0] = '0;
		den_in[0] = den;
		for (int k = 1; k < QUO_W; k++) begin
			rem_in[k] = rem_s[k-1];
			low_in[k] = low_s[k-1];
			quo_in[k] = quo_s[k-1];
			den_in[k] = den_s[k-1];
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_in[k], low_in[k][QUO_W-1]};
		assign diff  = trial - {1'b0, den_in[k]};
		assign ge    = trial >= {1'b0, den_in[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k] <= low_in[k] << 1;
				quo_s[k] <= {quo_in[k][QUO_W-2:0], ge};
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/segint_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segint_chk
// Port-level checks for the segment intersection unit.
// ----------------------------------------------------------------------------
module segint_chk #(
	parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         hit,
	input wire segint_pkg::status_t          status,
	input wire logic signed [COORD_BITS-1:0] cross_x,
	input wire logic signed [COORD_BITS-1:0] cross_y
);
	import segint_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cross_x))
		else $error("output transfer dropped while stalled");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (status == ST_INTERSECT)))
		else $error("hit and status disagree");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> cross_x == '0 && cross_y == '0)
		else $error("nonzero point without hit");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_INTERSECT || status == ST_PARALLEL ||
		              status == ST_OUTSIDE)
		else $error("undefined status code");

endmodule

bind segment_intersection_unit segint_chk #(.COORD_BITS(COORD_BITS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.status    (status),
	.cross_x   (cross_x),
	.cross_y   (cross_y)
);
`default_nettype wire
